@@ src/sync_length_frame_deframer_top_macros.svh @@
// Assertion macros for the deframer RTL.
`ifndef SYNC_LENGTH_FRAME_DEFRAMER_TOP_MACROS_SVH
`define SYNC_LENGTH_FRAME_DEFRAMER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked check, disabled while reset is high.
`define SLFD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds during reset.
`define SLFD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SLFD_ASSERT(label, clk, rst, prop, msg)
`define SLFD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

@@ src/slfd_pkg.sv @@
// Types and constants of the sync and length frame deframer.
`timescale 1ns / 1ps
`default_nettype none
package slfd_pkg;

   localparam logic [7:0] SYNC_FIRST_RESET  = 8'ha5;
   localparam logic [7:0] SYNC_SECOND_RESET = 8'h01;

   localparam int POS_W = 17;
   localparam logic [POS_W-1:0] LEN_LOW_POS  = 17'd3;
   localparam logic [POS_W-1:0] LEN_HIGH_POS = 17'd4;
   localparam logic [POS_W-1:0] FRAME_EXTRA  = 17'd8;
   localparam logic [POS_W-1:0] MIN_END_POS  = 17'd7;

   localparam int CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_FIRST  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_SECOND = 8'd1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   typedef struct packed {
      logic [7:0]       out_byte;
      logic [POS_W-1:0] byte_position;
      logic             frame_end;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   typedef struct packed {
      logic [QUEUE_CNT_W-1:0] count;
      logic                   has_room;
   } queue_status_type;

endpackage
`default_nettype wire

@@ src/slfd_parser.sv @@
// Frame state tracking and result generation for one byte per cycle while step is high.
`timescale 1ns / 1ps
`default_nettype none
module slfd_parser (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         step,
   input  wire  [7:0]                  in_byte,
   input  wire  [7:0]                  sync_first,
   input  wire  [7:0]                  sync_second,
   output slfd_pkg::push_type          push
);

   logic [slfd_pkg::POS_W-1:0] position_ff, position_in;
   logic [7:0]                 held_first_ff, held_first_in;
   logic [7:0]                 len_low_ff, len_low_in;
   logic [slfd_pkg::POS_W-1:0] total_ff, total_in;
   logic                       is_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff   <= '0;
         held_first_ff <= '0;
         len_low_ff    <= '0;
         total_ff      <= '0;
      end else begin
         position_ff   <= position_in;
         held_first_ff <= held_first_in;
         len_low_ff    <= len_low_in;
         total_ff      <= total_in;
      end
   end

   always_comb begin
      position_in   = position_ff;
      held_first_in = held_first_ff;
      len_low_in    = len_low_ff;
      total_in      = total_ff;
      is_end        = 1'b0;
      push          = '0;
      push.first    = '{out_byte: in_byte, byte_position: position_ff, frame_end: 1'b0};
      push.second   = '{out_byte: in_byte, byte_position: position_ff, frame_end: 1'b0};
      if (step) begin
         if (position_ff == '0) begin
            held_first_in = in_byte;
            position_in   = 17'd1;
         end else if (position_ff == 17'd1) begin
            if (held_first_ff != sync_first || in_byte != sync_second) begin
               position_in = '0;
            end else begin
               push.count                = 2'd2;
               push.first.out_byte       = held_first_ff;
               push.first.byte_position  = '0;
               push.second.byte_position = 17'd1;
               position_in               = 17'd2;
            end
         end else begin
            if (position_ff == slfd_pkg::LEN_LOW_POS) begin
               len_low_in = in_byte;
            end
            if (position_ff == slfd_pkg::LEN_HIGH_POS) begin
               total_in = {1'b0, in_byte, len_low_ff} + slfd_pkg::FRAME_EXTRA;
            end
            // The end can only fall once the length is known.
            is_end = (position_ff >= slfd_pkg::LEN_HIGH_POS) &&
                     (({1'b0, position_ff} + 18'd1) == {1'b0, total_in});
            push.count           = 2'd1;
            push.first.frame_end = is_end;
            position_in          = is_end ? '0 : position_ff + 17'd1;
         end
      end
   end

endmodule
`default_nettype wire

@@ src/slfd_queue.sv @@
// Small result queue that takes up to two entries and gives one per cycle while pop is high.
`timescale 1ns / 1ps
`default_nettype none
module slfd_queue (
   input  wire                              clock,
   input  wire                              reset,
   input  wire  slfd_pkg::push_type         push,
   input  wire                              pop,
   output slfd_pkg::result_type             head,
   output logic                             not_empty,
   output slfd_pkg::queue_status_type       status
);

   slfd_pkg::result_type mem [slfd_pkg::QUEUE_DEPTH];

   logic [slfd_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [slfd_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [slfd_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic [slfd_pkg::QUEUE_PTR_W-1:0] wr_next_ptr;
   logic                             do_pop;

   assign do_pop      = pop && (count_ff != '0);
   assign wr_next_ptr = wr_ptr_ff + slfd_pkg::QUEUE_PTR_W'(1);
   assign wr_ptr_in   = wr_ptr_ff + slfd_pkg::QUEUE_PTR_W'(push.count);
   assign rd_ptr_in   = rd_ptr_ff + slfd_pkg::QUEUE_PTR_W'(do_pop);
   assign count_in    = count_ff + slfd_pkg::QUEUE_CNT_W'(push.count)
                        - slfd_pkg::QUEUE_CNT_W'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[wr_next_ptr] <= push.second;
      end
   end

   assign head      = mem[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   // Room for the largest burst one byte can cause.
   assign status    = '{count: count_ff,
                        has_room: (count_ff <=
                                   slfd_pkg::QUEUE_CNT_W'(slfd_pkg::QUEUE_DEPTH - 2))};

endmodule
`default_nettype wire

@@ src/sync_length_frame_deframer_top.sv @@
// Top level of the sync and length frame deframer.
//
// The block takes received serial bytes on the req_ channel, one per transfer, and
// returns the bytes of each accepted frame on the rsp_ channel, one per transfer,
// with the byte's position in its frame and a mark on the final byte. A frame opens
// with two sync bytes that must match the sync_first and sync_second registers;
// on a mismatch both are dropped and the hunt starts again. Bytes 3 and 4 hold an
// unsigned little-endian content length, and the frame is that length plus 8 long.
// The two sync bytes come out as two transfers once the second one is checked.
// The csr_ channel writes the sync registers (index 0 and 1); other indexes are
// ignored. It is always ready and should be used only while the block is idle.
// A byte accepted on req_ is registered in the input register, then checked by
// the parser and written into the result queue, whose head is offered on rsp_.
// One byte can be taken every cycle while the queue has room. The four-entry
// result queue takes a byte only while it has room for two results; the first
// sync byte gives no result and the second gives two, so a steady stream to a
// ready receiver never waits. When the receiver stalls the queue fills and
// req_ready falls; nothing is lost. Reset clears the frame state, the queue and
// the input register, and loads the sync registers with 0xa5 and 0x01.
`timescale 1ns / 1ps
`default_nettype none
`include "sync_length_frame_deframer_top_macros.svh"
module sync_length_frame_deframer_top (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire  [7:0]                           req_in_byte,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic [7:0]                           rsp_out_byte,
   output logic [slfd_pkg::POS_W-1:0]           rsp_byte_position,
   output logic                                 rsp_frame_end,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [slfd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [7:0]                           csr_wdata
);

   // Configuration registers.
   logic [7:0] sync_first_ff, sync_first_in;
   logic [7:0] sync_second_ff, sync_second_in;

   // Input register holding one received byte.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;

   logic                              advance;
   slfd_pkg::push_type                push;
   slfd_pkg::result_type              head;
   slfd_pkg::queue_status_type        queue_status;

   assign csr_ready = 1'b1;

   // Register decode for the configuration port.
   always_comb begin
      sync_first_in  = sync_first_ff;
      sync_second_in = sync_second_ff;
      if (csr_valid) begin
         unique case (csr_index)
            slfd_pkg::CSR_SYNC_FIRST:  sync_first_in  = csr_wdata;
            slfd_pkg::CSR_SYNC_SECOND: sync_second_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= slfd_pkg::SYNC_FIRST_RESET;
         sync_second_ff <= slfd_pkg::SYNC_SECOND_RESET;
      end else begin
         sync_first_ff  <= sync_first_in;
         sync_second_ff <= sync_second_in;
      end
   end

   // The held byte moves into the parser when the queue can take its results.
   // A new byte is taken whenever the input register is empty or emptying.
   assign advance     = in_valid_ff && queue_status.has_room;
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = (req_valid && req_ready) ? 1'b1 : (in_valid_ff && !advance);
   assign in_byte_in  = (req_valid && req_ready) ? req_in_byte : in_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   slfd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .in_byte     (in_byte_ff),
      .sync_first  (sync_first_ff),
      .sync_second (sync_second_ff),
      .push        (push)
   );

   slfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_ready),
      .head      (head),
      .not_empty (rsp_valid),
      .status    (queue_status)
   );

   assign rsp_out_byte      = head.out_byte;
   assign rsp_byte_position = head.byte_position;
   assign rsp_frame_end     = head.frame_end;

   // The queue never holds more entries than it has. While reset is high the
   // count may not be known yet, so the check passes then.
   `SLFD_ASSERT_ALWAYS(a_queue_bound, clock,
      reset || queue_status.count <= slfd_pkg::QUEUE_CNT_W'(slfd_pkg::QUEUE_DEPTH),
      "result queue overflow")

   // A two-result burst is always the sync pair at positions zero and one.
   `SLFD_ASSERT(a_sync_pair, clock, reset,
      push.count == 2'd2 |-> (push.first.byte_position == '0 &&
                              push.second.byte_position == 17'd1),
      "sync pair positions wrong")

   // No frame is shorter than eight bytes.
   `SLFD_ASSERT(a_min_frame, clock, reset,
      rsp_valid && rsp_frame_end |-> rsp_byte_position >= slfd_pkg::MIN_END_POS,
      "frame ended too early")

   // Results are only produced for a byte that was held in the input register.
   `SLFD_ASSERT(a_push_source, clock, reset,
      push.count != 2'd0 |-> advance,
      "result produced without an input byte")

endmodule
`default_nettype wire

@@ dv/sync_length_frame_deframer_top_tb.sv @@
// Self-checking testbench of the sync and length frame deframer top level.
`timescale 1ns / 1ps
module sync_length_frame_deframer_top_tb;

   // Indexes that decode to no register; writes to them must change nothing.
   localparam logic [slfd_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_LOW = 8'd2;
   localparam logic [slfd_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_TOP = 8'hff;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [7:0]                       req_in_byte = 8'h00;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b1;
   logic [7:0]                       rsp_out_byte;
   logic [slfd_pkg::POS_W-1:0]       rsp_byte_position;
   logic                             rsp_frame_end;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [slfd_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [7:0]                       csr_wdata = 8'h00;

   sync_length_frame_deframer_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_position (rsp_byte_position),
      .rsp_frame_end     (rsp_frame_end),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Mirror of the deframer: sync registers, hunt/frame position, the held first
   // byte, the low length byte and the total frame length once it is known.
   logic [7:0]                 sync_first_mirror = slfd_pkg::SYNC_FIRST_RESET;
   logic [7:0]                 sync_second_mirror = slfd_pkg::SYNC_SECOND_RESET;
   logic [slfd_pkg::POS_W-1:0] frame_pos = '0;
   logic [7:0]                 held_sync_byte = 8'h00;
   logic [7:0]                 held_len_low = 8'h00;
   logic [slfd_pkg::POS_W-1:0] frame_length = '0;

   // Frame bytes that the block owes us, oldest first.
   slfd_pkg::result_type expected_frame_bytes[$];

   int unsigned failures = 0;
   int unsigned bytes_taken = 0;
   int unsigned results_checked = 0;
   int unsigned frames_closed = 0;
   int unsigned longest_frame = 0;
   int unsigned sync_settings = 1;

   // Idle rates in percent, drawn per byte for the sender and per cycle for the receiver.
   int unsigned req_gap_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned rsp_stall_left = 0;

   // Advances the mirror by one received byte and queues the frame bytes it
   // releases. The first sync byte is only held; the second one either releases
   // both or sends the hunt back to the start. From byte 2 on every byte comes
   // out, and the end can only be found once the length high byte has been seen.
   function automatic void deframe_byte(input logic [7:0] rx);
      logic closes;
      if (frame_pos == '0) begin
         held_sync_byte = rx;
         frame_pos = 17'd1;
      end else if (frame_pos == 17'd1) begin
         if (held_sync_byte != sync_first_mirror || rx != sync_second_mirror) begin
            frame_pos = '0;
         end else begin
            expected_frame_bytes.push_back({held_sync_byte, 17'd0, 1'b0});
            expected_frame_bytes.push_back({rx, 17'd1, 1'b0});
            frame_pos = 17'd2;
         end
      end else begin
         if (frame_pos == slfd_pkg::LEN_LOW_POS) begin
            held_len_low = rx;
         end else if (frame_pos == slfd_pkg::LEN_HIGH_POS) begin
            frame_length = {1'b0, rx, held_len_low} + slfd_pkg::FRAME_EXTRA;
         end
         closes = (frame_pos >= slfd_pkg::LEN_HIGH_POS) &&
                  (frame_pos + 17'd1 == frame_length);
         expected_frame_bytes.push_back({rx, frame_pos, closes});
         frame_pos = closes ? '0 : frame_pos + 17'd1;
      end
   endfunction

   // Every transfer is observed at the rising edge. Register writes update the
   // mirror, accepted bytes feed the prediction, and each result transfer is
   // compared field by field with the oldest expected frame byte.
   always @(posedge clock) begin : monitor
      slfd_pkg::result_type got;
      slfd_pkg::result_type want;
      if (reset) begin
         sync_first_mirror = slfd_pkg::SYNC_FIRST_RESET;
         sync_second_mirror = slfd_pkg::SYNC_SECOND_RESET;
         frame_pos = '0;
         held_sync_byte = 8'h00;
         held_len_low = 8'h00;
         frame_length = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               slfd_pkg::CSR_SYNC_FIRST: sync_first_mirror = csr_wdata;
               slfd_pkg::CSR_SYNC_SECOND: sync_second_mirror = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            bytes_taken++;
            deframe_byte(req_in_byte);
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_out_byte, rsp_byte_position, rsp_frame_end};
            if (expected_frame_bytes.size() == 0) begin
               $error("unexpected result transfer: byte %0h at position %0d, end %0b",
                      got.out_byte, got.byte_position, got.frame_end);
               failures++;
            end else begin
               want = expected_frame_bytes.pop_front();
               results_checked++;
               if (got.out_byte != want.out_byte) begin
                  $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
                  failures++;
               end
               if (got.byte_position != want.byte_position) begin
                  $error("byte_position: expected %0d, got %0d",
                         want.byte_position, got.byte_position);
                  failures++;
               end
               if (got.frame_end != want.frame_end) begin
                  $error("frame_end: expected %0b, got %0b", want.frame_end, got.frame_end);
                  failures++;
               end
               if (want.frame_end) begin
                  frames_closed++;
                  if (int'(want.byte_position) + 1 > longest_frame) begin
                     longest_frame = int'(want.byte_position) + 1;
                  end
               end
            end
         end
      end
   end

   // The receiver drops ready in random bursts at the rate set for the phase.
   always @(negedge clock) begin
      if (rsp_stall_left != 0) begin
         rsp_stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(99, 0) < rsp_stall_pct) begin
         rsp_stall_left = $urandom_range(9, 1) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Offers one byte, maybe after an idle burst, and returns at the falling edge
   // after its transfer. Valid stays high so the next byte can follow at once.
   task automatic send_byte(input logic [7:0] value);
      int unsigned gap = 0;
      if ($urandom_range(99, 0) < req_gap_pct) gap = $urandom_range(9, 1);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= value;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
   endtask

   // One register write. With more set, valid stays high for a following write.
   task automatic write_csr(input logic [slfd_pkg::CSR_INDEX_W-1:0] index,
                            input logic [7:0] value, input bit more);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      if (!more) csr_valid <= 1'b0;
   endtask

   // Stops the sender and waits until every owed frame byte has arrived, then
   // lets a byte that releases nothing clear the input register and the parser.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_frame_bytes.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // A well-formed frame under the current sync setting with random content.
   task automatic send_frame(input logic [15:0] payload_len);
      send_byte(sync_first_mirror);
      send_byte(sync_second_mirror);
      send_byte(8'($urandom_range(255, 0)));
      send_byte(payload_len[7:0]);
      send_byte(payload_len[15:8]);
      repeat (int'(payload_len) + 3) send_byte(8'($urandom_range(255, 0)));
   endtask

   // Reset values of the sync registers and the shortest frame, with content at
   // both byte extremes.
   task automatic test_default_sync_frame();
      send_byte(slfd_pkg::SYNC_FIRST_RESET);
      send_byte(slfd_pkg::SYNC_SECOND_RESET);
      send_byte(8'hff);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(8'h80);
   endtask

   // A wrong first byte and then a wrong second byte; both pairs are dropped.
   task automatic test_sync_mismatch();
      send_byte(8'h00);
      send_byte(slfd_pkg::SYNC_SECOND_RESET);
      send_byte(slfd_pkg::SYNC_FIRST_RESET);
      send_byte(8'hfe);
   endtask

   // Writes both registers and two unused indexes. The old sync pair must now
   // fail. A first byte is then held while sync_first changes, and it must be
   // judged against the new value when the second byte arrives.
   task automatic test_sync_registers();
      wait_drained();
      write_csr(slfd_pkg::CSR_SYNC_SECOND, 8'h00, 1'b1);
      write_csr(CSR_UNUSED_LOW, 8'h55, 1'b1);
      write_csr(CSR_UNUSED_TOP, 8'haa, 1'b0);
      send_byte(slfd_pkg::SYNC_FIRST_RESET);
      send_byte(slfd_pkg::SYNC_SECOND_RESET);
      send_byte(8'h3c);
      wait_drained();
      write_csr(slfd_pkg::CSR_SYNC_FIRST, 8'h3c, 1'b0);
      send_byte(8'h00);
      send_byte(8'h11);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h22);
      send_byte(8'h33);
      send_byte(8'h7f);
      sync_settings += 2;
   endtask

   // Phases of mostly well-formed frames with random content, mixed with noise
   // and broken sync pairs. Each phase starts idle with a new sync setting; the
   // last phase runs without idling on either side.
   task automatic test_random_traffic();
      int unsigned phase;
      int unsigned start_count;
      int unsigned pick;
      int unsigned burst;
      logic [7:0]  sync_a;
      logic [7:0]  sync_b;
      logic [7:0]  noise;
      bit          paused = 1'b0;
      for (phase = 0; phase < 7; phase++) begin
         wait_drained();
         sync_a = 8'($urandom_range(255, 0));
         sync_b = 8'($urandom_range(255, 0));
         case (phase)
            0: begin sync_a = 8'hff; sync_b = 8'h00; end
            1: begin sync_a = 8'h00; sync_b = 8'hff; end
            3: begin
               sync_a = slfd_pkg::SYNC_FIRST_RESET;
               sync_b = slfd_pkg::SYNC_SECOND_RESET;
            end
            4: begin sync_a = 8'h00; sync_b = 8'h00; end
            5: begin sync_a = 8'hff; sync_b = 8'hff; end
            default: ;
         endcase
         write_csr(slfd_pkg::CSR_SYNC_FIRST, sync_a, 1'b1);
         write_csr(slfd_pkg::CSR_SYNC_SECOND, sync_b, 1'b1);
         write_csr(8'($urandom_range(255, 2)), 8'($urandom_range(255, 0)), 1'b0);
         sync_settings++;
         if (phase == 6) begin
            req_gap_pct = 0;
            rsp_stall_pct = 0;
         end else begin
            req_gap_pct = 20 * $urandom_range(2, 0);
            rsp_stall_pct = 20 * $urandom_range(2, 0);
         end
         // One frame with a nonzero length high byte.
         if (phase == 1) send_frame(16'h0100 + 16'($urandom_range(15, 0)));
         start_count = bytes_taken;
         while (bytes_taken - start_count < 45) begin
            // Once, the sender holds off until the block has delivered everything.
            if (phase == 2 && !paused && bytes_taken - start_count >= 30) begin
               wait_drained();
               paused = 1'b1;
            end
            pick = $urandom_range(99, 0);
            if (pick < 65) begin
               send_frame(16'($urandom_range(20, 0)));
            end else if (pick < 72) begin
               send_frame(16'($urandom_range(60, 21)));
            end else if (pick < 85) begin
               // Noise never completes a sync pair, so it cannot open a frame.
               burst = $urandom_range(6, 1);
               repeat (burst) begin
                  noise = 8'($urandom_range(255, 0));
                  if (frame_pos == 17'd1 && held_sync_byte == sync_first_mirror &&
                      noise == sync_second_mirror) begin
                     noise = ~noise;
                  end
                  send_byte(noise);
               end
               // A lone held byte is flushed so the next frame starts in step.
               if (frame_pos == 17'd1) send_byte(~sync_second_mirror);
            end else if (pick < 92) begin
               send_byte(sync_first_mirror);
               send_byte(~sync_second_mirror);
            end else begin
               send_byte(~sync_first_mirror);
               send_byte(sync_second_mirror);
            end
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      req_gap_pct = 30;
      rsp_stall_pct = 30;
      test_default_sync_frame();
      test_sync_mismatch();
      test_sync_registers();
      test_random_traffic();
      wait_drained();
      repeat (4) @(negedge clock);
      $display("Sent %0d bytes under %0d sync settings; checked %0d frame bytes.",
               bytes_taken, sync_settings, results_checked);
      $display("Closed %0d frames, the longest %0d bytes.", frames_closed, longest_frame);
      if (failures == 0 && expected_frame_bytes.size() == 0) begin
         $display("sync_length_frame_deframer_top test passed");
      end else begin
         $display("sync_length_frame_deframer_top test failed");
      end
      $finish;
   end

   // The slowest correct run stays far below this timeout.
   initial begin
      #(64'd24_000_000);
      $display("sync_length_frame_deframer_top test failed");
      $finish;
   end

endmodule
